// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the checkers of this block.
// All of them sample on aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checked on every edge, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) \
        else $error(msg);

`endif

// File: rtl/core/ptspi_pkg.sv
`timescale 1ns / 1ps

package ptspi_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int PERIOD_WIDTH   = 16;

    localparam int GAIN_W = 10;
    localparam int CLK_W  = 24;
    localparam int SPD_W  = 8;
    localparam int ERR_W  = 8;
    localparam int DRV_W  = 8;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // accumulator: drive << frac plus two gain*error products, with headroom
    localparam int ACC_W = (((SPD_W + GAIN_FRAC_BITS) > (GAIN_W + ERR_W)) ?
                            (SPD_W + GAIN_FRAC_BITS) : (GAIN_W + ERR_W)) + 3;

    localparam int DIV_CNT_W = $clog2(CLK_W);
    localparam int MAC_CNT_W = $clog2(ERR_W);

    localparam logic [GAIN_W-1:0] KP_RESET    = GAIN_W'(102);
    localparam logic [GAIN_W-1:0] KPKI_RESET  = GAIN_W'(179);
    localparam logic [CLK_W-1:0]  CLK_RESET   = CLK_W'(250000);
    localparam logic [DRV_W-1:0]  DRIVE_RESET = DRV_W'(30);

    typedef enum logic [1:0] {
        REG_KP   = 2'd0,
        REG_KPKI = 2'd1,
        REG_CLK  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [SPD_W-1:0]        desired_speed;
        logic [PERIOD_WIDTH-1:0] period_count;
    } in_item_t;

    typedef struct packed {
        logic [DRV_W-1:0]        drive;
        logic [SPD_W-1:0]        speed;
        logic signed [ERR_W-1:0] speed_error;
        logic                    zero_period;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] kpki;
        logic [CLK_W-1:0]  clk;
    } cfg_t;

    typedef struct packed {
        logic                    start;
        logic [CLK_W-1:0]        dividend;
        logic [PERIOD_WIDTH-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [SPD_W-1:0] quotient;
    } div_stat_t;

    typedef struct packed {
        logic                    start;
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] last_err;
        logic [DRV_W-1:0]        last_drive;
        logic [GAIN_W-1:0]       kp;
        logic [GAIN_W-1:0]       kpki;
    } mac_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DRV_W-1:0] drive;
    } mac_stat_t;

endpackage

// File: rtl/core/ptspi_regs.sv
`timescale 1ns / 1ps

module ptspi_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptspi_pkg::ADDR_W-1:0] paddr,
    input  logic [ptspi_pkg::DATA_W-1:0] pwdata,
    output logic [ptspi_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output ptspi_pkg::cfg_t              cfg
);

    logic [ptspi_pkg::GAIN_W-1:0] kp_reg;
    logic [ptspi_pkg::GAIN_W-1:0] kpki_reg;
    logic [ptspi_pkg::CLK_W-1:0]  clk_reg;
    logic [1:0]                   idx;
    logic                         wr_en;

    assign idx    = paddr[ptspi_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg   <= ptspi_pkg::KP_RESET;
            kpki_reg <= ptspi_pkg::KPKI_RESET;
            clk_reg  <= ptspi_pkg::CLK_RESET;
        end else if (wr_en) begin
            case (idx)
                ptspi_pkg::REG_KP:   kp_reg   <= pwdata[ptspi_pkg::GAIN_W-1:0];
                ptspi_pkg::REG_KPKI: kpki_reg <= pwdata[ptspi_pkg::GAIN_W-1:0];
                ptspi_pkg::REG_CLK:  clk_reg  <= pwdata[ptspi_pkg::CLK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ptspi_pkg::REG_KP:   prdata = ptspi_pkg::DATA_W'(kp_reg);
            ptspi_pkg::REG_KPKI: prdata = ptspi_pkg::DATA_W'(kpki_reg);
            ptspi_pkg::REG_CLK:  prdata = ptspi_pkg::DATA_W'(clk_reg);
            default:             prdata = '0;
        endcase
    end

    assign cfg.kp   = kp_reg;
    assign cfg.kpki = kpki_reg;
    assign cfg.clk  = clk_reg;

endmodule

// File: rtl/core/ptspi_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
// Only the low byte of the quotient is kept; anything above it saturates.
module ptspi_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptspi_pkg::div_cmd_t  cmd,
    output ptspi_pkg::div_stat_t stat
);

    typedef enum logic {DV_IDLE, DV_RUN} dv_state_t;

    dv_state_t                          state_reg, state_next;
    logic [ptspi_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ptspi_pkg::CLK_W-1:0]        dvd_reg, dvd_next;
    logic [ptspi_pkg::PERIOD_WIDTH-1:0] dsr_reg, dsr_next;
    logic [ptspi_pkg::PERIOD_WIDTH-1:0] rem_reg, rem_next;
    logic [ptspi_pkg::SPD_W-1:0]        q_reg, q_next;
    logic                               ovf_reg, ovf_next;
    logic                               done_reg, done_next;
    logic [ptspi_pkg::SPD_W-1:0]        quot_reg, quot_next;

    logic [ptspi_pkg::PERIOD_WIDTH:0]   trial;
    logic [ptspi_pkg::PERIOD_WIDTH:0]   diff;
    logic                               qbit;

    always_comb begin
        trial = {rem_reg, dvd_reg[ptspi_pkg::CLK_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        qbit  = !diff[ptspi_pkg::PERIOD_WIDTH];

        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        dsr_next   = dsr_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        ovf_next   = ovf_reg;
        done_next  = 1'b0;
        quot_next  = quot_reg;

        case (state_reg)
            DV_IDLE: begin
                if (cmd.start) begin
                    state_next = DV_RUN;
                    cnt_next   = ptspi_pkg::DIV_CNT_W'(ptspi_pkg::CLK_W - 1);
                    dvd_next   = cmd.dividend;
                    dsr_next   = cmd.divisor;
                    rem_next   = '0;
                    q_next     = '0;
                    ovf_next   = 1'b0;
                end
            end
            DV_RUN: begin
                rem_next = qbit ? diff[ptspi_pkg::PERIOD_WIDTH-1:0]
                                : trial[ptspi_pkg::PERIOD_WIDTH-1:0];
                dvd_next = {dvd_reg[ptspi_pkg::CLK_W-2:0], 1'b0};
                q_next   = {q_reg[ptspi_pkg::SPD_W-2:0], qbit};
                // a one pushed out of the byte means quotient > 255
                ovf_next = ovf_reg | q_reg[ptspi_pkg::SPD_W-1];
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = DV_IDLE;
                    done_next  = 1'b1;
                    quot_next  = ovf_next ? {ptspi_pkg::SPD_W{1'b1}} : q_next;
                end
            end
            default: state_next = DV_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        quot_reg <= quot_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quot_reg;

endmodule

// File: rtl/core/ptspi_mac.sv
`timescale 1ns / 1ps

// Serial PI update: one bit of both errors per cycle, LSB first.
// acc = (last_drive << frac) + kpki*err - kp*last_err; the error MSB carries
// negative weight, so its step subtracts.
module ptspi_mac (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ptspi_pkg::mac_cmd_t  cmd,
    output ptspi_pkg::mac_stat_t stat
);

    localparam int AW = ptspi_pkg::ACC_W;
    localparam int FB = ptspi_pkg::GAIN_FRAC_BITS;
    localparam int DW = ptspi_pkg::DRV_W;
    localparam int EW = ptspi_pkg::ERR_W;

    typedef enum logic [1:0] {MC_IDLE, MC_RUN, MC_FIN} mc_state_t;

    mc_state_t                       state_reg, state_next;
    logic [ptspi_pkg::MAC_CNT_W-1:0] cnt_reg, cnt_next;
    logic signed [AW-1:0]            acc_reg, acc_next;
    logic [AW-1:0]                   a_reg, a_next;
    logic [AW-1:0]                   b_reg, b_next;
    logic [EW-1:0]                   e_reg, e_next;
    logic [EW-1:0]                   l_reg, l_next;
    logic                            done_reg, done_next;
    logic [DW-1:0]                   drive_reg, drive_next;

    logic signed [AW-1:0]            term;

    always_comb begin
        term = $signed(e_reg[0] ? a_reg : {AW{1'b0}})
             - $signed(l_reg[0] ? b_reg : {AW{1'b0}});

        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        e_next     = e_reg;
        l_next     = l_reg;
        done_next  = 1'b0;
        drive_next = drive_reg;

        case (state_reg)
            MC_IDLE: begin
                if (cmd.start) begin
                    state_next = MC_RUN;
                    cnt_next   = '0;
                    acc_next   = {{(AW - DW - FB){1'b0}}, cmd.last_drive, {FB{1'b0}}};
                    a_next     = {{(AW - ptspi_pkg::GAIN_W){1'b0}}, cmd.kpki};
                    b_next     = {{(AW - ptspi_pkg::GAIN_W){1'b0}}, cmd.kp};
                    e_next     = cmd.err;
                    l_next     = cmd.last_err;
                end
            end
            MC_RUN: begin
                acc_next = (cnt_reg == ptspi_pkg::MAC_CNT_W'(EW - 1)) ? acc_reg - term
                                                                      : acc_reg + term;
                a_next   = {a_reg[AW-2:0], 1'b0};
                b_next   = {b_reg[AW-2:0], 1'b0};
                e_next   = {1'b0, e_reg[EW-1:1]};
                l_next   = {1'b0, l_reg[EW-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == ptspi_pkg::MAC_CNT_W'(EW - 1)) begin
                    state_next = MC_FIN;
                end
            end
            MC_FIN: begin
                state_next = MC_IDLE;
                done_next  = 1'b1;
                if (acc_reg[AW-1]) begin
                    drive_next = '0;
                end else if (|acc_reg[AW-2:FB+DW]) begin
                    drive_next = {DW{1'b1}};
                end else begin
                    drive_next = acc_reg[FB+DW-1:FB];
                end
            end
            default: state_next = MC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MC_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        e_reg     <= e_next;
        l_reg     <= l_next;
        drive_reg <= drive_next;
    end

    assign stat.done  = done_reg;
    assign stat.drive = drive_reg;

endmodule

// File: rtl/core/period_to_speed_pi_controller_top.sv
`timescale 1ns / 1ps

// Period-to-speed PI controller. Each input transfer carries a setpoint and a
// captured timer period; the block divides clock_over_speed by the period
// (bit-serial divider), saturates speed at 255, forms the signed byte error and
// runs a serial velocity-form PI step (one error bit per cycle) that saturates
// the drive to 0..255. A zero period skips the divider. One item is worked at
// a time; s_ready is high only while the sequencer is idle, and the output
// register lets a new item start while a result waits for m_ready.
// Registers sit on the APB port at 0x0 (kp), 0x4 (kp+ki), 0x8 (clock constant).
module period_to_speed_pi_controller_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  ptspi_pkg::in_item_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output ptspi_pkg::out_item_t         m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptspi_pkg::ADDR_W-1:0] paddr,
    input  logic [ptspi_pkg::DATA_W-1:0] pwdata,
    output logic [ptspi_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_ERR, ST_MAC, ST_OUT} st_t;

    ptspi_pkg::cfg_t      cfg;
    ptspi_pkg::div_cmd_t  div_cmd;
    ptspi_pkg::div_stat_t div_stat;
    ptspi_pkg::mac_cmd_t  mac_cmd;
    ptspi_pkg::mac_stat_t mac_stat;

    st_t                                 state_reg;
    logic [ptspi_pkg::SPD_W-1:0]         desired_reg;
    logic [ptspi_pkg::SPD_W-1:0]         speed_reg;
    logic                                zero_reg;
    logic signed [ptspi_pkg::ERR_W-1:0]  err_reg;
    logic [ptspi_pkg::DRV_W-1:0]         drive_reg;
    logic signed [ptspi_pkg::ERR_W-1:0]  last_err_reg;
    logic [ptspi_pkg::DRV_W-1:0]         last_drive_reg;
    logic                                m_valid_reg;
    ptspi_pkg::out_item_t                m_data_reg;

    logic                                s_xfer;
    logic                                period_zero;
    logic [ptspi_pkg::SPD_W:0]           diff;
    logic signed [ptspi_pkg::ERR_W-1:0]  err_next;
    logic                                out_free;

    ptspi_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptspi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .stat    (div_stat)
    );

    ptspi_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .stat    (mac_stat)
    );

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_xfer      = s_valid && s_ready;
    assign period_zero = (s_data.period_count == '0);
    assign out_free    = !m_valid_reg || m_ready;

    assign div_cmd.start    = s_xfer && !period_zero;
    assign div_cmd.dividend = cfg.clk;
    assign div_cmd.divisor  = s_data.period_count;

    // desired - speed fits 9 bits signed; clamp when bit 8 and bit 7 disagree
    always_comb begin
        diff = {1'b0, desired_reg} - {1'b0, speed_reg};
        if (diff[ptspi_pkg::SPD_W] != diff[ptspi_pkg::SPD_W-1]) begin
            err_next = diff[ptspi_pkg::SPD_W] ? {1'b1, {(ptspi_pkg::ERR_W-1){1'b0}}}
                                              : {1'b0, {(ptspi_pkg::ERR_W-1){1'b1}}};
        end else begin
            err_next = diff[ptspi_pkg::ERR_W-1:0];
        end
    end

    assign mac_cmd.start      = (state_reg == ST_ERR);
    assign mac_cmd.err        = err_next;
    assign mac_cmd.last_err   = last_err_reg;
    assign mac_cmd.last_drive = last_drive_reg;
    assign mac_cmd.kp         = cfg.kp;
    assign mac_cmd.kpki       = cfg.kpki;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            last_err_reg   <= '0;
            last_drive_reg <= ptspi_pkg::DRIVE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            // ST_OUT reloads the output register itself
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_xfer) begin
                        desired_reg <= s_data.desired_speed;
                        zero_reg    <= period_zero;
                        speed_reg   <= '0;
                        state_reg   <= period_zero ? ST_ERR : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_stat.done) begin
                        speed_reg <= div_stat.quotient;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    err_reg   <= err_next;
                    state_reg <= ST_MAC;
                end
                ST_MAC: begin
                    if (mac_stat.done) begin
                        drive_reg <= mac_stat.drive;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg.drive       <= drive_reg;
                        m_data_reg.speed       <= speed_reg;
                        m_data_reg.speed_error <= err_reg;
                        m_data_reg.zero_period <= zero_reg;
                        m_valid_reg            <= 1'b1;
                        last_err_reg           <= err_reg;
                        last_drive_reg         <= drive_reg;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/ptspi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptspi_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ptspi_pkg::out_item_t m_data
);

    // a waiting result holds until its transfer
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped or changed while stalled")

    // nothing pending right after reset
    `ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_valid, "result valid after reset")

    // a zero period must report zero speed
    `ASSERT_CLK(a_zero_speed, m_valid && m_data.zero_period |-> m_data.speed == '0, "zero period with nonzero speed")

    // one item at a time: busy right after an input transfer
    `ASSERT_CLK(a_busy_after_in, s_valid && s_ready |=> !s_ready, "input taken while item in flight")

endmodule

bind period_to_speed_pi_controller_top ptspi_checker u_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int HOLD_OFF_AT     = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CALM_FIRST      = 700;
    localparam int CALM_LAST       = 1000;
    localparam int PHASE_ITEMS     = 300;
    localparam int NUM_PHASES      = 6;
    localparam int UNMAPPED_IDX    = 3;

    typedef struct {
        bit                           is_write;
        int                           idx;
        logic [ptspi_pkg::DATA_W-1:0] wdata;
        ptspi_pkg::in_item_t          item;
        bit                           typed;
        ptspi_pkg::out_item_t         want;
    } script_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    ptspi_pkg::in_item_t           s_data;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    ptspi_pkg::out_item_t          m_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ptspi_pkg::ADDR_W-1:0]  paddr;
    logic [ptspi_pkg::DATA_W-1:0]  pwdata;
    logic [ptspi_pkg::DATA_W-1:0]  prdata;
    logic                          pready;

    // controller shadow: registers and loop state
    logic [ptspi_pkg::GAIN_W-1:0]  kp_q;
    logic [ptspi_pkg::GAIN_W-1:0]  kpki_q;
    logic [ptspi_pkg::CLK_W-1:0]   clk_q;
    int                            prev_err;
    logic [ptspi_pkg::DRV_W-1:0]   prev_drive;

    ptspi_pkg::out_item_t          pending_q[$];
    int                            fail_cnt = 0;
    int                            n_sent = 0;
    int                            results_seen = 0;
    int                            stall_left = 0;
    bit                            hold_done = 1'b0;
    int                            idle_cycles = 0;

    period_to_speed_pi_controller_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // speed from period, saturated error, then one velocity-form PI step
    function automatic ptspi_pkg::out_item_t pi_update(ptspi_pkg::in_item_t it);
        ptspi_pkg::out_item_t res;
        longint               quot;
        longint               acc;
        int                   err;
        res.zero_period = (it.period_count == '0);
        if (res.zero_period) begin
            res.speed = '0;
        end else begin
            quot = longint'(clk_q) / longint'(it.period_count);
            res.speed = (quot > 255) ? ptspi_pkg::SPD_W'(255) : ptspi_pkg::SPD_W'(quot);
        end
        err = int'(it.desired_speed) - int'(res.speed);
        if (err > 127) err = 127;
        else if (err < -128) err = -128;
        acc = (longint'(prev_drive) << ptspi_pkg::GAIN_FRAC_BITS)
              + longint'(kpki_q) * err - longint'(kp_q) * prev_err;
        if (acc < 0) res.drive = '0;
        else if ((acc >>> ptspi_pkg::GAIN_FRAC_BITS) > 255)
            res.drive = ptspi_pkg::DRV_W'(255);
        else res.drive = ptspi_pkg::DRV_W'(acc >>> ptspi_pkg::GAIN_FRAC_BITS);
        res.speed_error = ptspi_pkg::ERR_W'(err);
        prev_err   = err;
        prev_drive = res.drive;
        return res;
    endfunction

    function automatic script_row_t item_row(int d, int p, bit typed = 1'b0,
                                             ptspi_pkg::out_item_t want = '0);
        script_row_t row;
        row.is_write = 1'b0;
        row.idx = 0;
        row.wdata = '0;
        row.item.desired_speed = ptspi_pkg::SPD_W'(d);
        row.item.period_count = ptspi_pkg::PERIOD_WIDTH'(p);
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    function automatic script_row_t reg_row(int idx, logic [ptspi_pkg::DATA_W-1:0] v);
        script_row_t row;
        row = item_row(0, 0);
        row.is_write = 1'b1;
        row.idx = idx;
        row.wdata = v;
        return row;
    endfunction

    // write, then read back when the index maps to a register
    task automatic reg_write(input int idx, input logic [ptspi_pkg::DATA_W-1:0] data);
        logic [ptspi_pkg::DATA_W-1:0] held;
        bit                           mapped;
        mapped = 1'b1;
        held = '0;
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ptspi_pkg::ADDR_W'(4 * idx);
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            ptspi_pkg::REG_KP: begin
                kp_q = data[ptspi_pkg::GAIN_W-1:0];
                held = ptspi_pkg::DATA_W'(kp_q);
            end
            ptspi_pkg::REG_KPKI: begin
                kpki_q = data[ptspi_pkg::GAIN_W-1:0];
                held = ptspi_pkg::DATA_W'(kpki_q);
            end
            ptspi_pkg::REG_CLK: begin
                clk_q = data[ptspi_pkg::CLK_W-1:0];
                held = ptspi_pkg::DATA_W'(clk_q);
            end
            default: mapped = 1'b0;
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (mapped) begin
            psel <= 1'b1;
            pwrite <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            if (prdata !== held) begin
                $error("register %0d: expected %0h, got %0h", idx, held, prdata);
                fail_cnt++;
            end
            psel <= 1'b0;
            penable <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_item(input ptspi_pkg::in_item_t it, input bit typed,
                             input ptspi_pkg::out_item_t want);
        ptspi_pkg::out_item_t got;
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        got = pi_update(it);
        pending_q.push_back(typed ? want : got);
        if (!(n_sent >= CALM_FIRST && n_sent < CALM_LAST) && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // result side: ready pattern plus field-by-field comparison
    always @(posedge aclk) begin : result_side
        ptspi_pkg::out_item_t want;
        bit                   calm;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_q.size() == 0) begin
                    $error("unexpected result: drive %0d speed %0d", m_data.drive,
                           m_data.speed);
                    fail_cnt++;
                end else begin
                    want = pending_q.pop_front();
                    if (m_data.drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, m_data.drive);
                        fail_cnt++;
                    end
                    if (m_data.speed !== want.speed) begin
                        $error("speed: expected %0d, got %0d", want.speed, m_data.speed);
                        fail_cnt++;
                    end
                    if (m_data.speed_error !== want.speed_error) begin
                        $error("speed_error: expected %0d, got %0d", want.speed_error,
                               m_data.speed_error);
                        fail_cnt++;
                    end
                    if (m_data.zero_period !== want.zero_period) begin
                        $error("zero_period: expected %0d, got %0d", want.zero_period,
                               m_data.zero_period);
                        fail_cnt++;
                    end
                end
            end
            calm = (results_seen >= CALM_FIRST && results_seen < CALM_LAST);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_OFF_AT) begin
                // long back-pressure so the block fills and stalls its input
                hold_done = 1'b1;
                stall_left = HOLD_OFF_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(99) < 9) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        script_row_t                  script[$];
        ptspi_pkg::in_item_t          it;
        logic [ptspi_pkg::DATA_W-1:0] k;
        logic [ptspi_pkg::DATA_W-1:0] ki;
        logic [ptspi_pkg::DATA_W-1:0] c;
        int                           sp;
        int                           r;
        int                           per;
        int                           d;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        kp_q = ptspi_pkg::KP_RESET;
        kpki_q = ptspi_pkg::KPKI_RESET;
        clk_q = ptspi_pkg::CLK_RESET;
        prev_err = 0;
        prev_drive = ptspi_pkg::DRIVE_RESET;

        // first two outputs follow directly from the reset state
        script.push_back(item_row(0, 0, 1'b1, '{drive: 8'd30, speed: 8'd0,
                                               speed_error: 8'sd0, zero_period: 1'b1}));
        script.push_back(item_row(255, 1, 1'b1, '{drive: 8'd30, speed: 8'd255,
                                                 speed_error: 8'sd0, zero_period: 1'b0}));
        script.push_back(item_row(255, 0));          // error clips high
        script.push_back(item_row(255, 0));
        script.push_back(item_row(0, 1));            // error clips low
        script.push_back(item_row(0, 1));
        script.push_back(item_row(0, 65535));
        script.push_back(item_row(128, 980));        // quotient 255, then 254 (ratio just over 255)
        script.push_back(item_row(128, 981));
        script.push_back(item_row(170, 16'h5555));
        script.push_back(item_row(85, 16'hAAAA));
        script.push_back(item_row(100, 2500));
        script.push_back(reg_row(ptspi_pkg::REG_KP, 1023));
        script.push_back(reg_row(ptspi_pkg::REG_KPKI, 1023));
        script.push_back(item_row(255, 0));          // drive clips at 255
        script.push_back(item_row(255, 0));
        script.push_back(item_row(0, 1));            // negative sum, drive 0
        script.push_back(reg_row(ptspi_pkg::REG_CLK, 0));       // zero clock constant
        script.push_back(item_row(200, 1234));
        script.push_back(reg_row(ptspi_pkg::REG_CLK, 32'hFFFF_FFFF));
        script.push_back(item_row(0, 65535));
        script.push_back(reg_row(UNMAPPED_IDX, 32'h0001_2345));
        script.push_back(reg_row(ptspi_pkg::REG_KP, 32'hFFFF_F066));
        script.push_back(reg_row(ptspi_pkg::REG_KPKI, 32'hABCD_E0B3));
        script.push_back(reg_row(ptspi_pkg::REG_CLK, 32'hFF03_D090));
        script.push_back(item_row(37, 6000));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].is_write) begin
                drain();
                reg_write(script[i].idx, script[i].wdata);
            end else begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin
                    k = ptspi_pkg::DATA_W'(ptspi_pkg::KP_RESET);
                    ki = ptspi_pkg::DATA_W'(ptspi_pkg::KPKI_RESET);
                    c = ptspi_pkg::DATA_W'(ptspi_pkg::CLK_RESET);
                end
                1: begin k = 1023; ki = 1023; c = 32'h00FF_FFFF; end
                2: begin k = 0; ki = 0; c = 1; end
                3: begin k = 0; ki = 1023; c = 65536; end
                4: begin k = $urandom; ki = $urandom; c = $urandom; end
                default: begin k = 512; ki = 700; c = 250000; end
            endcase
            drain();
            reg_write(ptspi_pkg::REG_KP, k);
            reg_write(ptspi_pkg::REG_KPKI, ki);
            reg_write(ptspi_pkg::REG_CLK, c);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sp = $urandom_range(1, 255);
                r = $urandom_range(99);
                if (r < 8) begin
                    per = 0;
                end else if (r < 22) begin
                    per = $urandom_range(0, 65535);
                end else if (r < 30) begin
                    per = $urandom_range(1, 300);
                end else if (clk_q == '0) begin
                    per = $urandom_range(1, 65535);
                end else begin
                    // period that lands near a chosen speed
                    per = int'(clk_q / sp) + int'($urandom_range(0, 8)) - 4;
                    if (per < 1) per = 1;
                    if (per > 65535) per = 65535;
                end
                if ($urandom_range(99) < 35) begin
                    d = $urandom_range(0, 255);
                end else begin
                    d = sp + int'($urandom_range(0, 16)) - 8;
                    if (d < 0) d = 0;
                    if (d > 255) d = 255;
                end
                it.desired_speed = ptspi_pkg::SPD_W'(d);
                it.period_count = ptspi_pkg::PERIOD_WIDTH'(per);
                send_item(it, 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_cnt == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
